>>> hw/rtl/bba_pkg.sv
// Shared types, constants and codes of the buddy block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int LEVELS_DEF        = 13;
    localparam int MIN_BLOCK_LOG_DEF = 4;
    localparam int HEADER_BYTES_DEF  = 768;

    localparam logic [1:0] RES_OK     = 2'd0;
    localparam logic [1:0] RES_NOFREE = 2'd1;
    localparam logic [1:0] RES_BADOFF = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_HINIT,
        OP_HNODE,
        OP_INCL,
        OP_DECL,
        OP_LOAD,
        OP_POPR,
        OP_POPW,
        OP_TGLW,
        OP_AINC,
        OP_PUSHA,
        OP_PUSHB,
        OP_FRD,
        OP_UNLINK
    } dp_op_t;

    typedef enum logic [4:0] {
        S_CLR,
        S_HINIT,
        S_HCHK,
        S_HNEXT,
        S_IDLE,
        S_DISP,
        S_ASRCH,
        S_APOPW,
        S_ATGW,
        S_ACHK,
        S_FRD,
        S_FCHK,
        S_PA,
        S_PB,
        S_FIN
    } ctrl_state_t;

    typedef enum logic [1:0] {
        CTX_HDR,
        CTX_ALLOC,
        CTX_FREE
    } push_ctx_t;

    typedef struct packed {
        dp_op_t     op;
        logic       load_res;
        logic [1:0] res_status;
        logic       res_use_off;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic bad_off;
        logic lvl_bad;
        logic lvl_zero;
        logic head_empty;
        logic pair_bit;
        logic at_target;
        logic hdr_take;
        logic hdr_last;
        logic hdr_big;
        logic clr_done;
    } dp_stat_t;

endpackage

>>> hw/rtl/buddy_block_allocator_top.sv
// Top level of the buddy block allocator: controller plus datapath.
//
//  Channel  Direction  Handshake         Word
//  s_       in         s_valid/s_ready   s_command, s_level, s_offset
//  m_       out        m_valid/m_ready   m_status, m_block_offset
//
// After reset the pair-bit memory is cleared, one entry a cycle, all 2^(LEVELS-1) entries,
// then the header walk goes level by level and queues each buddy that lies above the header.
// An allocate searches the free lists from the requested level towards larger blocks and splits down.
// A free merges with its buddy at each level whose pair bit is set, then pushes the final block;
// each level costs one pair-memory read followed by the link-memory updates.
// One word is worked at a time; a finished result waits in the output register.
`timescale 1ns / 1ps

module buddy_block_allocator_top import bba_pkg::*; #(
    parameter int LEVELS        = LEVELS_DEF,
    parameter int MIN_BLOCK_LOG = MIN_BLOCK_LOG_DEF,
    parameter int HEADER_BYTES  = HEADER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [3:0]  s_level,
    input  logic [15:0] s_offset,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_block_offset
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bba_dpath #(
        .LEVELS        (LEVELS),
        .MIN_BLOCK_LOG (MIN_BLOCK_LOG),
        .HEADER_BYTES  (HEADER_BYTES)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_command      (s_command),
        .s_level        (s_level),
        .s_offset       (s_offset),
        .m_status       (m_status),
        .m_block_offset (m_block_offset)
    );

endmodule

>>> hw/rtl/bba_dpath.sv
// Datapath of the buddy allocator: free lists, pair bits, link memories and result word.
`timescale 1ns / 1ps

module bba_dpath import bba_pkg::*; #(
    parameter int LEVELS        = LEVELS_DEF,
    parameter int MIN_BLOCK_LOG = MIN_BLOCK_LOG_DEF,
    parameter int HEADER_BYTES  = HEADER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic        s_command,
    input  logic [3:0]  s_level,
    input  logic [15:0] s_offset,
    output logic [1:0]  m_status,
    output logic [15:0] m_block_offset
);

    localparam int CAP_LOG = LEVELS - 1 + MIN_BLOCK_LOG;
    localparam int OW      = CAP_LOG;
    localparam int NIW     = LEVELS - 1;
    localparam int NW      = LEVELS;
    localparam int NODES   = 1 << NIW;
    localparam int LW      = $clog2(LEVELS);
    localparam int XW      = (OW > 16) ? OW : 16;
    localparam longint CAPACITY = longint'(1) << CAP_LOG;
    localparam logic HDR_BIG = longint'(HEADER_BYTES) >= CAPACITY;
    localparam logic [NW-1:0] NONE_V = {1'b1, {NIW{1'b0}}};

    function automatic logic [OW-1:0] blk(input logic [LW-1:0] l);
        blk = OW'(1) << (CAP_LOG - int'(l));
    endfunction

    function automatic logic [NIW-1:0] pidx(input logic [OW-1:0] o, input logic [LW-1:0] l);
        int            pl;
        logic [OW-1:0] q;
        pl   = int'(l) - 1;
        q    = o >> (CAP_LOG - pl);
        pidx = NIW'(q) + ((NIW'(1) << pl) - NIW'(1));
    endfunction

    function automatic logic [NIW-1:0] node(input logic [OW-1:0] o);
        node = o[OW-1:MIN_BLOCK_LOG];
    endfunction

    logic [NW-1:0]  head_reg [LEVELS];
    logic [NW-1:0]  tail_reg [LEVELS];
    logic           pair_mem [NODES];
    logic [NW-1:0]  next_mem [NODES];
    logic [NW-1:0]  prev_mem [NODES];

    logic           is_free_reg, bad_off_reg, lvl_bad_reg;
    logic [LW-1:0]  lvl_reg, tgt_reg;
    logic [OW-1:0]  off_reg;
    logic [NIW-1:0] node_reg;
    logic [NW-1:0]  tmp_reg;
    logic [NIW-1:0] clr_reg;
    logic           pair_rd_reg;
    logic [NW-1:0]  next_rd_reg, prev_rd_reg;
    logic [1:0]     m_status_reg;
    logic [15:0]    m_boff_reg;

    logic           pw_en, pw_data, pr_en;
    logic [NIW-1:0] pw_addr, pr_addr;
    logic           nw_en, nr_en, vw_en, vr_en;
    logic [NIW-1:0] nw_addr, nr_addr, vw_addr, vr_addr;
    logic [NW-1:0]  nw_data, vw_data;

    logic [NW-1:0]  head_cur, tail_cur;
    logic [OW-1:0]  cur_blk, hdr_bud, in_off, bud_off;
    logic [NIW-1:0] cur_pidx;
    logic [LW-1:0]  in_lvl, lvl_inc;
    logic           in_lvl_bad, in_bad_off;
    logic [XW-1:0]  off_ext;

    assign head_cur = head_reg[lvl_reg];
    assign tail_cur = tail_reg[lvl_reg];
    assign cur_blk  = blk(lvl_reg);
    assign cur_pidx = pidx(off_reg, lvl_reg);
    assign bud_off  = off_reg ^ cur_blk;
    assign hdr_bud  = (off_reg & ~(cur_blk - OW'(1))) ^ cur_blk;
    assign lvl_inc  = lvl_reg + LW'(1);
    assign in_lvl   = LW'(s_level);
    assign in_lvl_bad = (s_level == 4'd0) || (int'(s_level) >= LEVELS);
    assign off_ext  = XW'(s_offset);
    assign in_off   = OW'(off_ext);
    assign in_bad_off = (s_offset == 16'd0) || (longint'(s_offset) >= CAPACITY);

    always_comb begin
        pw_en = 1'b0; pw_addr = cur_pidx; pw_data = ~pair_rd_reg;
        pr_en = 1'b0; pr_addr = cur_pidx;
        nw_en = 1'b0; nw_addr = node_reg; nw_data = NONE_V;
        nr_en = 1'b0; nr_addr = node(bud_off);
        vw_en = 1'b0; vw_addr = node_reg; vw_data = NONE_V;
        vr_en = 1'b0; vr_addr = node(bud_off);
        case (cmd.op)
            OP_CLR: begin
                pw_en = 1'b1; pw_addr = clr_reg; pw_data = 1'b0;
            end
            OP_POPR: begin
                nr_en = 1'b1; nr_addr = head_cur[NIW-1:0];
            end
            OP_POPW: begin
                pr_en = 1'b1;
                vw_en = !next_rd_reg[NW-1];
                vw_addr = next_rd_reg[NIW-1:0];
            end
            OP_TGLW: pw_en = 1'b1;
            OP_PUSHA: begin
                pr_en = 1'b1;
                nw_en = 1'b1;
                vw_en = 1'b1;
                vw_data = tail_cur[NW-1] ? NONE_V : tail_cur;
            end
            OP_PUSHB: begin
                pw_en = 1'b1;
                nw_en = !tmp_reg[NW-1];
                nw_addr = tmp_reg[NIW-1:0];
                nw_data = NW'(node_reg);
            end
            OP_FRD: begin
                pr_en = 1'b1; nr_en = 1'b1; vr_en = 1'b1;
            end
            OP_UNLINK: begin
                pw_en = 1'b1;
                nw_en = !prev_rd_reg[NW-1];
                nw_addr = prev_rd_reg[NIW-1:0];
                nw_data = next_rd_reg[NW-1] ? NONE_V : next_rd_reg;
                vw_en = !next_rd_reg[NW-1];
                vw_addr = next_rd_reg[NIW-1:0];
                vw_data = prev_rd_reg[NW-1] ? NONE_V : prev_rd_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pw_en) begin
            pair_mem[pw_addr] <= pw_data;
        end
        if (pr_en) begin
            pair_rd_reg <= pair_mem[pr_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (nw_en) begin
            next_mem[nw_addr] <= nw_data;
        end
        if (nr_en) begin
            next_rd_reg <= next_mem[nr_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (vw_en) begin
            prev_mem[vw_addr] <= vw_data;
        end
        if (vr_en) begin
            prev_rd_reg <= prev_mem[vr_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= NONE_V;
                tail_reg[i] <= NONE_V;
            end
            clr_reg <= '0;
        end else begin
            case (cmd.op)
                OP_CLR: clr_reg <= clr_reg + NIW'(1);
                OP_POPW: begin
                    head_reg[lvl_reg] <= next_rd_reg[NW-1] ? NONE_V : next_rd_reg;
                    if (next_rd_reg[NW-1]) begin
                        tail_reg[lvl_reg] <= NONE_V;
                    end
                end
                OP_PUSHA: begin
                    tail_reg[lvl_reg] <= NW'(node_reg);
                    if (tail_cur[NW-1]) begin
                        head_reg[lvl_reg] <= NW'(node_reg);
                    end
                end
                OP_UNLINK: begin
                    if (prev_rd_reg[NW-1]) begin
                        head_reg[lvl_reg] <= next_rd_reg[NW-1] ? NONE_V : next_rd_reg;
                    end
                    if (next_rd_reg[NW-1]) begin
                        tail_reg[lvl_reg] <= prev_rd_reg[NW-1] ? NONE_V : prev_rd_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_HINIT: begin
                off_reg <= OW'(HEADER_BYTES);
                lvl_reg <= LW'(1);
            end
            OP_HNODE: node_reg <= node(hdr_bud);
            OP_INCL:  lvl_reg <= lvl_inc;
            OP_DECL:  lvl_reg <= lvl_reg - LW'(1);
            OP_LOAD: begin
                is_free_reg <= s_command;
                bad_off_reg <= in_bad_off;
                lvl_bad_reg <= in_lvl_bad;
                lvl_reg     <= in_lvl;
                tgt_reg     <= in_lvl;
                off_reg     <= in_off & ~(blk(in_lvl) - OW'(1));
            end
            OP_POPR: begin
                node_reg <= head_cur[NIW-1:0];
                off_reg  <= {head_cur[NIW-1:0], {MIN_BLOCK_LOG{1'b0}}};
            end
            OP_AINC: begin
                lvl_reg  <= lvl_inc;
                node_reg <= node(off_reg + blk(lvl_inc));
            end
            OP_PUSHA: tmp_reg <= tail_cur;
            OP_FRD:   node_reg <= node(off_reg);
            OP_UNLINK: begin
                off_reg <= off_reg & ~cur_blk;
                lvl_reg <= lvl_reg - LW'(1);
            end
            default: ;
        endcase
        if (cmd.load_res) begin
            m_status_reg <= cmd.res_status;
            m_boff_reg   <= cmd.res_use_off ? 16'(XW'(off_reg)) : 16'd0;
        end
    end

    assign stat.is_free    = is_free_reg;
    assign stat.bad_off    = bad_off_reg;
    assign stat.lvl_bad    = lvl_bad_reg;
    assign stat.lvl_zero   = (lvl_reg == '0);
    assign stat.head_empty = head_cur[NW-1];
    assign stat.pair_bit   = pair_rd_reg;
    assign stat.at_target  = (lvl_reg == tgt_reg);
    assign stat.hdr_take   = (hdr_bud > off_reg);
    assign stat.hdr_last   = (lvl_reg == LW'(LEVELS - 2));
    assign stat.hdr_big    = HDR_BIG;
    assign stat.clr_done   = &clr_reg;

    assign m_status       = m_status_reg;
    assign m_block_offset = m_boff_reg;

endmodule

>>> hw/rtl/bba_ctrl.sv
// Controller state machine of the buddy allocator: sequences pops, pushes and merges.
`timescale 1ns / 1ps

module bba_ctrl import bba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    push_ctx_t   ctx_reg, ctx_next;
    logic [1:0]  code_reg, code_next;
    logic        use_off_reg, use_off_next;
    logic        out_vld_reg, out_vld_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            ctx_reg     <= CTX_HDR;
            code_reg    <= RES_OK;
            use_off_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ctx_reg     <= ctx_next;
            code_reg    <= code_next;
            use_off_reg <= use_off_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        ctx_next     = ctx_reg;
        code_next    = code_reg;
        use_off_next = use_off_reg;
        cmd          = '{op: OP_NONE, load_res: 1'b0, res_status: code_reg,
                         res_use_off: use_off_reg};
        s_ready      = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd.op = OP_CLR;
                if (stat.clr_done) begin
                    state_next = stat.hdr_big ? S_IDLE : S_HINIT;
                end
            end
            S_HINIT: begin
                cmd.op = OP_HINIT;
                state_next = S_HCHK;
            end
            S_HCHK: begin
                if (stat.hdr_take) begin
                    cmd.op = OP_HNODE;
                    ctx_next = CTX_HDR;
                    state_next = S_PA;
                end else begin
                    state_next = S_HNEXT;
                end
            end
            S_HNEXT: begin
                if (stat.hdr_last) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.op = OP_INCL;
                    state_next = S_HCHK;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                use_off_next = 1'b0;
                if (stat.is_free) begin
                    if (stat.bad_off) begin
                        code_next = RES_BADOFF;
                        state_next = S_FIN;
                    end else if (stat.lvl_bad) begin
                        code_next = RES_OK;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_FRD;
                    end
                end else if (stat.lvl_bad) begin
                    code_next = RES_NOFREE;
                    state_next = S_FIN;
                end else begin
                    state_next = S_ASRCH;
                end
            end
            S_ASRCH: begin
                if (stat.lvl_zero) begin
                    code_next = RES_NOFREE;
                    state_next = S_FIN;
                end else if (!stat.head_empty) begin
                    cmd.op = OP_POPR;
                    state_next = S_APOPW;
                end else begin
                    cmd.op = OP_DECL;
                end
            end
            S_APOPW: begin
                cmd.op = OP_POPW;
                state_next = S_ATGW;
            end
            S_ATGW: begin
                cmd.op = OP_TGLW;
                state_next = S_ACHK;
            end
            S_ACHK: begin
                if (stat.at_target) begin
                    code_next = RES_OK;
                    use_off_next = 1'b1;
                    state_next = S_FIN;
                end else begin
                    cmd.op = OP_AINC;
                    ctx_next = CTX_ALLOC;
                    state_next = S_PA;
                end
            end
            S_FRD: begin
                if (stat.lvl_zero) begin
                    code_next = RES_OK;
                    state_next = S_FIN;
                end else begin
                    cmd.op = OP_FRD;
                    state_next = S_FCHK;
                end
            end
            S_FCHK: begin
                if (stat.pair_bit) begin
                    cmd.op = OP_UNLINK;
                    state_next = S_FRD;
                end else begin
                    ctx_next = CTX_FREE;
                    state_next = S_PA;
                end
            end
            S_PA: begin
                cmd.op = OP_PUSHA;
                state_next = S_PB;
            end
            S_PB: begin
                cmd.op = OP_PUSHB;
                unique case (ctx_reg)
                    CTX_HDR:   state_next = S_HNEXT;
                    CTX_ALLOC: state_next = S_ACHK;
                    CTX_FREE: begin
                        code_next = RES_OK;
                        state_next = S_FIN;
                    end
                    default:   state_next = S_IDLE;
                endcase
            end
            S_FIN: begin
                if (!out_vld_reg || m_ready) begin
                    cmd.load_res = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (cmd.load_res) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    assign m_valid = out_vld_reg;

    a_accept_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DISP)
        else $error("accepted word did not reach dispatch");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_res |-> (!m_valid || m_ready))
        else $error("result word overwritten while waiting");

    a_rise_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.load_res))
        else $error("result valid raised without a load");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op != OP_NONE && cmd.op != OP_LOAD) |-> !s_ready)
        else $error("input ready while datapath busy");

endmodule

>>> tb/sv/tb_buddy_block_allocator_top.sv
// Self-checking testbench of the buddy block allocator with its own allocator predictor.
`timescale 1ns / 1ps

module tb_buddy_block_allocator_top import bba_pkg::*;;

    localparam int CAP_LOG   = 16;
    localparam int NUM_NODES = 4096;
    localparam int NUM_LVLS  = 13;
    localparam int NO_NODE   = NUM_NODES;
    localparam int IDLE_LIMIT = 40000;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct {
        logic        command;
        logic [3:0]  level;
        logic [15:0] offset;
        logic [1:0]  status;
        logic [15:0] block_offset;
        bit          drain;
    } word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_command;
    logic [3:0]  s_level;
    logic [15:0] s_offset;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [15:0] m_block_offset;

    bit   pair_bit_mem[NUM_NODES];
    int   link_next[NUM_NODES];
    int   link_prev[NUM_NODES];
    int   queue_head[NUM_LVLS];
    int   queue_tail[NUM_LVLS];

    word_t       stim_q[$];
    word_t       owed_q[$];
    word_t       cur_word;
    int          live_off[$];
    int          live_lvl[$];
    int          mismatches;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    int          ready_pct;
    int          ready_timer;
    logic        s_took;

    buddy_block_allocator_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_level(s_level), .s_offset(s_offset),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_block_offset(m_block_offset)
    );

    function automatic int span_of(int lv);
        return 1 << (CAP_LOG - lv);
    endfunction

    function automatic int clip(int n);
        return (n < NUM_NODES) ? n : NO_NODE;
    endfunction

    function automatic int pair_index(int off, int lv);
        return (1 << lv) + (off >> (CAP_LOG - lv)) - 1;
    endfunction

    function automatic void flip_pair(int off, int lv);
        int idx;
        idx = pair_index(off, lv);
        if (idx < NUM_NODES) pair_bit_mem[idx] = !pair_bit_mem[idx];
    endfunction

    function automatic bit pair_is_set(int off, int lv);
        int idx;
        idx = pair_index(off, lv);
        return idx < NUM_NODES && pair_bit_mem[idx];
    endfunction

    function automatic void enqueue_block(int lv, int n);
        int t;
        t = clip(queue_tail[lv]);
        link_next[n] = NO_NODE;
        link_prev[n] = t;
        if (t == NO_NODE) queue_head[lv] = n;
        else link_next[t] = n;
        queue_tail[lv] = n;
    endfunction

    function automatic int dequeue_block(int lv);
        int n;
        int x;
        n = clip(queue_head[lv]);
        x = clip(link_next[n % NUM_NODES]);
        queue_head[lv] = x;
        if (x == NO_NODE) queue_tail[lv] = NO_NODE;
        else link_prev[x] = NO_NODE;
        return n % NUM_NODES;
    endfunction

    function automatic void remove_block(int lv, int n);
        int p;
        int x;
        p = clip(link_prev[n]);
        x = clip(link_next[n]);
        if (p != NO_NODE) link_next[p] = x;
        else queue_head[lv] = x;
        if (x != NO_NODE) link_prev[x] = p;
        else queue_tail[lv] = p;
    endfunction

    function automatic void reset_allocator();
        int p;
        int bud;
        p = 768;
        for (int i = 0; i < NUM_NODES; i++) begin
            pair_bit_mem[i] = 0;
            link_next[i] = 0;
            link_prev[i] = 0;
        end
        for (int lv = 0; lv < NUM_LVLS; lv++) begin
            queue_head[lv] = NO_NODE;
            queue_tail[lv] = NO_NODE;
        end
        for (int lv = 1; lv + 1 < NUM_LVLS; lv++) begin
            bud = (p & ~(span_of(lv) - 1)) ^ span_of(lv);
            if (bud > p) begin
                flip_pair(p, lv - 1);
                enqueue_block(lv, bud >> 4);
            end
        end
    endfunction

    // Applies one request to the allocator state and fills in the expected response.
    function automatic void allocator_step(ref word_t w);
        int lv;
        int k;
        int o;
        int cur;
        int bud;
        lv = w.level;
        w.status = RES_OK;
        w.block_offset = '0;
        if (w.command == CMD_ALLOC) begin
            if (lv == 0 || lv >= NUM_LVLS) begin
                w.status = RES_NOFREE;
            end else begin
                k = lv;
                while (k >= 1 && clip(queue_head[k]) == NO_NODE) k--;
                if (k == 0) begin
                    w.status = RES_NOFREE;
                end else begin
                    o = dequeue_block(k) << 4;
                    flip_pair(o, k - 1);
                    for (int m = k + 1; m <= lv; m++) begin
                        enqueue_block(m, ((o + span_of(m)) >> 4) % NUM_NODES);
                        flip_pair(o, m - 1);
                    end
                    w.block_offset = o[15:0];
                    live_off.push_back(o);
                    live_lvl.push_back(lv);
                end
            end
        end else if (w.offset == 0) begin
            w.status = RES_BADOFF;
        end else if (lv != 0 && lv < NUM_LVLS) begin
            cur = w.offset & ~(span_of(lv) - 1);
            while (lv > 0) begin
                if (pair_is_set(cur, lv - 1)) begin
                    bud = cur ^ span_of(lv);
                    remove_block(lv, bud >> 4);
                    flip_pair(cur, lv - 1);
                    if (bud < cur) cur = bud;
                    lv--;
                end else begin
                    enqueue_block(lv, cur >> 4);
                    flip_pair(cur, lv - 1);
                    break;
                end
            end
        end
    endfunction

    function automatic void add_word(logic cmd, int lv, int off, bit drain);
        word_t w;
        w.command = cmd;
        w.level = lv[3:0];
        w.offset = off[15:0];
        w.drain = drain;
        allocator_step(w);
        stim_q.push_back(w);
    endfunction

    function automatic void free_live(int idx, bit ragged, bit drain);
        int off;
        int lv;
        off = live_off[idx];
        lv = live_lvl[idx];
        live_off.delete(idx);
        live_lvl.delete(idx);
        if (ragged) off = off | ($urandom() & (span_of(lv) - 1));
        add_word(CMD_FREE, lv, off, drain);
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        int pick;
        int lv;
        aresetn = 1'b0;
        reset_allocator();
        add_word(CMD_ALLOC, 0, 16'hFFFF, 0);
        add_word(CMD_ALLOC, 13, 0, 0);
        add_word(CMD_ALLOC, 15, 0, 0);
        add_word(CMD_ALLOC, 12, 0, 0);
        add_word(CMD_ALLOC, 1, 0, 0);
        add_word(CMD_ALLOC, 1, 0, 0);
        add_word(CMD_ALLOC, 2, 0, 0);
        add_word(CMD_ALLOC, 12, 0, 0);
        add_word(CMD_FREE, 3, 0, 0);
        add_word(CMD_FREE, 0, 16'hFFFF, 0);
        add_word(CMD_FREE, 14, 16'h8000, 0);
        add_word(CMD_FREE, 15, 16'h0001, 0);
        free_live(0, 1, 0);
        free_live(live_off.size() - 1, 1, 0);
        free_live(0, 0, 0);
        add_word(CMD_ALLOC, 1, 0, 0);
        for (int i = 0; i < 750; i++) begin
            if ($urandom_range(0, 99) < 50 || live_off.size() == 0) begin
                lv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 12);
                add_word(CMD_ALLOC, lv, $urandom_range(0, 65535), i % 300 == 299);
            end else if ($urandom_range(0, 99) < 85) begin
                pick = $urandom_range(0, live_off.size() - 1);
                free_live(pick, $urandom_range(0, 1), i % 300 == 299);
            end else begin
                case ($urandom_range(0, 2))
                    0: add_word(CMD_FREE, $urandom_range(0, 15), 0, i % 300 == 299);
                    1: add_word(CMD_FREE, 0, $urandom_range(1, 65535), i % 300 == 299);
                    default: add_word(CMD_FREE, $urandom_range(13, 15), $urandom_range(1, 65535),
                                      i % 300 == 299);
                endcase
            end
        end
        reset_allocator();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stim_q.size() == 0 && !s_valid && owed_q.size() == 0);
        repeat (60) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_command <= CMD_ALLOC;
            s_level <= '0;
            s_offset <= '0;
            m_ready <= 1'b0;
            burst_left <= 4;
            gap_left <= 0;
            ready_pct <= 100;
            ready_timer <= 0;
        end else begin
            if (!s_valid || s_took) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (stim_q.size() > 0 && !(stim_q[0].drain && owed_q.size() > 0)) begin
                    cur_word = stim_q.pop_front();
                    s_valid <= 1'b1;
                    s_command <= cur_word.command;
                    s_level <= cur_word.level;
                    s_offset <= cur_word.offset;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (ready_timer == 0) begin
                ready_timer <= $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 70;
                    2: ready_pct <= 30;
                    default: ready_pct <= 5;
                endcase
            end else begin
                ready_timer <= ready_timer - 1;
            end
            m_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    always @(posedge aclk) begin
        word_t exp_w;
        s_took <= aresetn && s_valid && s_ready;
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if (s_valid && s_ready) owed_q.push_back(cur_word);
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Unexpected result word: status %0d offset %h",
                                 m_status, m_block_offset);
                end else begin
                    exp_w = owed_q.pop_front();
                    if (m_status !== exp_w.status || m_block_offset !== exp_w.block_offset) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("Mismatch cmd %0d lvl %0d off %h: expected %0d/%h got %0d/%h",
                                     exp_w.command, exp_w.level, exp_w.offset, exp_w.status,
                                     exp_w.block_offset, m_status, m_block_offset);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        mismatches = 0;
        s_took = 1'b0;
    end

endmodule

>>> filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_dpath.sv
hw/rtl/bba_ctrl.sv
hw/rtl/buddy_block_allocator_top.sv
tb/sv/tb_buddy_block_allocator_top.sv
